// ----- rtl/mstw_pkg.sv -----
// Shared types and constants for the minimum spanning tree weight block.
`default_nettype none
package mstw_pkg;
  localparam int VTX_W    = 6;
  localparam int WEIGHT_W = 16;
  localparam int TOTAL_W  = 24;

  localparam logic signed [TOTAL_W:0] TOTAL_MAX = 25'sd8388607;
  localparam logic signed [TOTAL_W:0] TOTAL_MIN = -25'sd8388608;

  typedef struct packed {
    logic [VTX_W-1:0]           from_v;
    logic [VTX_W-1:0]           to_v;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_FIND_A,
    ST_CHK_A,
    ST_FIND_B,
    ST_CHK_B,
    ST_DONE
  } back_state_t;
endpackage
`default_nettype wire

// ----- rtl/mstw_front.sv -----
// Front end: accepts edges, fills the edge memory and queues a run job.
`default_nettype none
module mstw_front import mstw_pkg::*; #(
  parameter int MAX_EDGES   = 256,
  parameter int WEIGHT_BITS = 16,
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int CW = $clog2(MAX_EDGES + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [VTX_W-1:0]           edge_from,
  input  wire logic [VTX_W-1:0]           edge_to,
  input  wire logic signed [WEIGHT_W-1:0] edge_weight,
  input  wire logic                       last_edge,
  input  wire logic                       busy,
  output logic                            full,
  output logic                            job_valid,
  output logic [CW-1:0]                   job_cnt,
  input  wire logic                       job_pop,
  input  wire logic                       rd_en,
  input  wire logic [EW-1:0]              rd_addr,
  output edge_t                           rd_data
);
  localparam int WB = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;

  edge_t                       mem [MAX_EDGES];
  logic [CW-1:0]               cnt;
  logic                        accept;
  logic                        room;
  logic signed [WEIGHT_W-1:0]  wt_sh;
  edge_t                       wr_item;

  assign full   = job_valid | busy;
  assign accept = push & ~full;
  assign room   = (32'(cnt) < MAX_EDGES);
  assign wt_sh  = edge_weight <<< (WEIGHT_W - WB);

  always_comb begin
    wr_item.from_v = edge_from;
    wr_item.to_v   = edge_to;
    wr_item.weight = wt_sh >>> (WEIGHT_W - WB);
  end

  always_ff @(posedge clk) begin
    if (accept && room) begin
      mem[cnt[EW-1:0]] <= wr_item;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      job_valid <= 1'b0;
      job_cnt   <= '0;
    end else begin
      if (job_pop) begin
        job_valid <= 1'b0;
      end
      if (accept) begin
        if (last_edge) begin
          cnt       <= '0;
          job_valid <= 1'b1;
          job_cnt   <= room ? cnt + CW'(1) : cnt;
        end else if (room) begin
          cnt <= cnt + CW'(1);
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/mstw_back.sv -----
// Back end: selection scan by weight and union-find over the parent memory.
`default_nettype none
module mstw_back import mstw_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int CW = $clog2(MAX_EDGES + 1),
  localparam int PV = (MAX_VERTICES < 64) ? MAX_VERTICES : 64,
  localparam int PW = $clog2(PV)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      job_valid,
  input  wire logic [CW-1:0]             job_cnt,
  output logic                           job_pop,
  output logic                           busy,
  output logic                           rd_en,
  output logic [EW-1:0]                  rd_addr,
  input  wire edge_t                     rd_data,
  input  wire logic                      pop,
  output logic                           empty,
  output logic signed [TOTAL_W-1:0]      total_weight
);
  back_state_t state, state_next;

  logic [PW-1:0]               parent [PV];
  logic [PW-1:0]               par_q;
  logic                        par_re;
  logic [PW-1:0]               par_raddr;
  logic                        par_we;
  logic [PW-1:0]               par_waddr, par_wdata;

  logic [PW-1:0]               clr_idx, clr_idx_next;
  logic [CW-1:0]               cnt, cnt_next;
  logic [CW-1:0]               rd_idx, rd_idx_next;
  logic                        scan_v, scan_v_next;
  logic [EW-1:0]               scan_idx, scan_idx_next;
  logic                        have_last, have_last_next;
  logic signed [WEIGHT_W-1:0]  last_wt, last_wt_next;
  logic [EW-1:0]               last_idx, last_idx_next;
  logic                        have_best, have_best_next;
  logic signed [WEIGHT_W-1:0]  best_wt, best_wt_next;
  logic [EW-1:0]               best_idx, best_idx_next;
  logic [VTX_W-1:0]            best_from, best_from_next;
  logic [VTX_W-1:0]            best_to, best_to_next;
  logic [PW-1:0]               node, node_next;
  logic [PW-1:0]               root_a, root_a_next;
  logic signed [TOTAL_W-1:0]   sum, sum_next;
  logic                        res_valid, res_valid_next;
  logic signed [TOTAL_W-1:0]   res, res_next;

  logic                        after_last, better, in_range;
  logic signed [TOTAL_W:0]     sum_wide;

  assign busy         = (state != ST_IDLE);
  assign empty        = ~res_valid;
  assign total_weight = res;

  always_ff @(posedge clk) begin
    if (par_we) begin
      parent[par_waddr] <= par_wdata;
    end
    if (par_re) begin
      par_q <= parent[par_raddr];
    end
  end

  always_comb begin
    after_last = ~have_last || (rd_data.weight > last_wt) ||
                 (rd_data.weight == last_wt && scan_idx > last_idx);
    better     = ~have_best || (rd_data.weight < best_wt);
    in_range   = (32'(best_from) < MAX_VERTICES) && (32'(best_to) < MAX_VERTICES);
    sum_wide   = 25'(sum) + 25'(best_wt);
  end

  always_comb begin
    state_next     = state;
    clr_idx_next   = clr_idx;
    cnt_next       = cnt;
    rd_idx_next    = rd_idx;
    scan_v_next    = 1'b0;
    scan_idx_next  = scan_idx;
    have_last_next = have_last;
    last_wt_next   = last_wt;
    last_idx_next  = last_idx;
    have_best_next = have_best;
    best_wt_next   = best_wt;
    best_idx_next  = best_idx;
    best_from_next = best_from;
    best_to_next   = best_to;
    node_next      = node;
    root_a_next    = root_a;
    sum_next       = sum;
    res_valid_next = res_valid & ~pop;
    res_next       = res;
    job_pop        = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = rd_idx[EW-1:0];
    par_re         = 1'b0;
    par_raddr      = node;
    par_we         = 1'b0;
    par_waddr      = clr_idx;
    par_wdata      = clr_idx;
    unique case (state)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop        = 1'b1;
          cnt_next       = job_cnt;
          clr_idx_next   = '0;
          sum_next       = '0;
          have_last_next = 1'b0;
          state_next     = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        par_we       = 1'b1;
        clr_idx_next = clr_idx + PW'(1);
        if (32'(clr_idx) == PV - 1) begin
          rd_idx_next    = '0;
          have_best_next = 1'b0;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_v && after_last && better) begin
          have_best_next = 1'b1;
          best_wt_next   = rd_data.weight;
          best_idx_next  = scan_idx;
          best_from_next = rd_data.from_v;
          best_to_next   = rd_data.to_v;
        end
        if (rd_idx < cnt) begin
          rd_en         = 1'b1;
          scan_v_next   = 1'b1;
          scan_idx_next = rd_idx[EW-1:0];
          rd_idx_next   = rd_idx + CW'(1);
        end else if (!scan_v) begin
          if (!have_best) begin
            state_next = ST_DONE;
          end else begin
            have_last_next = 1'b1;
            last_wt_next   = best_wt;
            last_idx_next  = best_idx;
            rd_idx_next    = '0;
            have_best_next = 1'b0;
            if (in_range) begin
              node_next  = best_from[PW-1:0];
              state_next = ST_FIND_A;
            end
          end
        end
      end
      ST_FIND_A: begin
        par_re     = 1'b1;
        state_next = ST_CHK_A;
      end
      ST_CHK_A: begin
        if (par_q == node) begin
          root_a_next = node;
          node_next   = best_to[PW-1:0];
          state_next  = ST_FIND_B;
        end else begin
          node_next  = par_q;
          state_next = ST_FIND_A;
        end
      end
      ST_FIND_B: begin
        par_re     = 1'b1;
        state_next = ST_CHK_B;
      end
      ST_CHK_B: begin
        if (par_q == node) begin
          if (node != root_a) begin
            par_we    = 1'b1;
            par_waddr = node;
            par_wdata = root_a;
            if (sum_wide > TOTAL_MAX) begin
              sum_next = TOTAL_MAX[TOTAL_W-1:0];
            end else if (sum_wide < TOTAL_MIN) begin
              sum_next = TOTAL_MIN[TOTAL_W-1:0];
            end else begin
              sum_next = sum_wide[TOTAL_W-1:0];
            end
          end
          state_next = ST_SCAN;
        end else begin
          node_next  = par_q;
          state_next = ST_FIND_B;
        end
      end
      ST_DONE: begin
        if (!res_valid) begin
          res_valid_next = 1'b1;
          res_next       = sum;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      scan_v    <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
      scan_v    <= scan_v_next;
    end
  end

  always_ff @(posedge clk) begin
    clr_idx   <= clr_idx_next;
    cnt       <= cnt_next;
    rd_idx    <= rd_idx_next;
    scan_idx  <= scan_idx_next;
    have_last <= have_last_next;
    last_wt   <= last_wt_next;
    last_idx  <= last_idx_next;
    have_best <= have_best_next;
    best_wt   <= best_wt_next;
    best_idx  <= best_idx_next;
    best_from <= best_from_next;
    best_to   <= best_to_next;
    node      <= node_next;
    root_a    <= root_a_next;
    sum       <= sum_next;
    res       <= res_next;
  end
endmodule
`default_nettype wire

// ----- rtl/minimum_spanning_tree_weight.sv -----
// Top level of the minimum spanning tree weight block.
// Input queue: push with edge_from, edge_to, edge_weight, last_edge; an item is
//   taken when push is high and full is low. Edges load one per cycle while full is low.
// Result queue: total_weight is valid while empty is low; pop takes it.
// An item with last_edge set closes the graph and starts a run; one result,
//   the spanning forest weight, follows. Edges beyond MAX_EDGES are dropped.
// A run for n stored edges first clears the PV parent memory entries,
//   PV = min(MAX_VERTICES, 64), then scans the edge memory once per edge in
//   weight order plus once to find none left, searches the roots of both ends
//   of each edge with parent memory reads, and then writes the result.
// full stays high from the last edge until the run ends; a new graph may load
//   while its result waits. A held result does not block the next graph's
//   load, but the next run waits for pop before its result is written.
// Reset clears the edge count, job queue, run state and result valid flag.
`default_nettype none
module minimum_spanning_tree_weight import mstw_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  parameter int WEIGHT_BITS  = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [VTX_W-1:0]           edge_from,
  input  wire logic [VTX_W-1:0]           edge_to,
  input  wire logic signed [WEIGHT_W-1:0] edge_weight,
  input  wire logic                       last_edge,
  input  wire logic                       pop,
  output logic                            empty,
  output logic signed [TOTAL_W-1:0]       total_weight
);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);

  logic          busy, job_valid, job_pop, rd_en;
  logic [CW-1:0] job_cnt;
  logic [EW-1:0] rd_addr;
  edge_t         rd_data;

  mstw_front #(.MAX_EDGES(MAX_EDGES), .WEIGHT_BITS(WEIGHT_BITS)) u_front (
    .clk(clk), .rst(rst), .push(push), .edge_from(edge_from), .edge_to(edge_to),
    .edge_weight(edge_weight), .last_edge(last_edge), .busy(busy), .full(full),
    .job_valid(job_valid), .job_cnt(job_cnt), .job_pop(job_pop),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  mstw_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job_cnt(job_cnt),
    .job_pop(job_pop), .busy(busy), .rd_en(rd_en), .rd_addr(rd_addr),
    .rd_data(rd_data), .pop(pop), .empty(empty), .total_weight(total_weight)
  );
endmodule
`default_nettype wire

// ----- rtl/mstw_checker.sv -----
// Port-level assertions for the minimum spanning tree weight block.
`default_nettype none
module mstw_checker import mstw_pkg::*; (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       push,
  input wire logic                       full,
  input wire logic                       last_edge,
  input wire logic                       pop,
  input wire logic                       empty,
  input wire logic signed [TOTAL_W-1:0]  total_weight
);
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");
  a_reset_open: assert property (@(posedge clk) rst |=> !full)
    else $error("input queue full after reset");
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (push && !full && last_edge) |=> full)
    else $error("input not closed after last edge");
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !last_edge && empty) |=> empty)
    else $error("result appeared while loading edges");
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(total_weight)))
    else $error("stalled result changed");
endmodule

bind minimum_spanning_tree_weight mstw_checker u_mstw_checker (
  .clk(clk), .rst(rst), .push(push), .full(full), .last_edge(last_edge),
  .pop(pop), .empty(empty), .total_weight(total_weight)
);
`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for minimum_spanning_tree_weight: fixed and random graphs, Kruskal scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import mstw_pkg::*;

  localparam int NV = 64;
  localparam int NE = 256;

  class mst_scoreboard;
    logic [VTX_W-1:0] src_q[$];
    logic [VTX_W-1:0] dst_q[$];
    int               wt_q[$];
    int               total_q[$];
    int               errors;
    int               reported;

    function int find_root(ref int par[NV], input int x);
      int r;
      int n;
      r = x;
      while (par[r] != r) r = par[r];
      while (par[x] != r) begin
        n = par[x];
        par[x] = r;
        x = n;
      end
      return r;
    endfunction

    function void note_edge(logic [VTX_W-1:0] f, logic [VTX_W-1:0] t,
                            logic signed [WEIGHT_W-1:0] w, logic lst);
      int par[NV];
      int ord[$];
      int sum;
      int ra;
      int rb;
      int k;
      if (src_q.size() < NE) begin
        src_q.push_back(f);
        dst_q.push_back(t);
        wt_q.push_back(int'(w));
      end
      if (!lst) return;
      for (int i = 0; i < NV; i++) par[i] = i;
      for (int i = 0; i < wt_q.size(); i++) begin
        int j;
        j = 0;
        while (j < ord.size() && wt_q[ord[j]] <= wt_q[i]) j++;
        ord.insert(j, i);
      end
      sum = 0;
      foreach (ord[i]) begin
        k = ord[i];
        ra = find_root(par, src_q[k]);
        rb = find_root(par, dst_q[k]);
        if (ra == rb) continue;
        par[rb] = ra;
        sum += wt_q[k];
        if (sum > 8388607) sum = 8388607;
        if (sum < -8388608) sum = -8388608;
      end
      total_q.push_back(sum);
      src_q.delete();
      dst_q.delete();
      wt_q.delete();
    endfunction

    function void check_total(logic signed [TOTAL_W-1:0] got);
      int want;
      if (total_q.size() == 0) begin
        errors++;
        if (reported++ < 10) $display("unexpected total %0d", got);
        return;
      end
      want = total_q.pop_front();
      if (int'(got) != want) begin
        errors++;
        if (reported++ < 10) $display("total mismatch: expected %0d actual %0d", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic pop = 0;
  logic [VTX_W-1:0] edge_from = '0;
  logic [VTX_W-1:0] edge_to = '0;
  logic signed [WEIGHT_W-1:0] edge_weight = '0;
  logic last_edge = 0;
  logic full;
  logic empty;
  logic signed [TOTAL_W-1:0] total_weight;
  int send_idle = 0;
  int recv_stall = 0;
  bit stim_done = 0;
  mst_scoreboard sb = new();

  minimum_spanning_tree_weight u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .edge_from(edge_from),
    .edge_to(edge_to), .edge_weight(edge_weight), .last_edge(last_edge),
    .pop(pop), .empty(empty), .total_weight(total_weight)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("minimum_spanning_tree_weight regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check_total(total_weight);
      pop <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send_edge(input logic [VTX_W-1:0] f, input logic [VTX_W-1:0] t,
                           input logic signed [WEIGHT_W-1:0] w, input logic lst);
    while ($urandom_range(99) < send_idle) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    edge_from <= f;
    edge_to <= t;
    edge_weight <= w;
    last_edge <= lst;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_edge(f, t, w, lst);
  endtask

  task automatic send_graph(input int n, input int nv);
    logic signed [WEIGHT_W-1:0] w;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: w = WEIGHT_W'($urandom);
        1: w = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        default: w = WEIGHT_W'(int'($urandom_range(200)) - 100);
      endcase
      send_edge(VTX_W'($urandom_range(nv - 1)), VTX_W'($urandom_range(nv - 1)), w,
                i == n - 1);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_edge(6'd0, 6'd63, 16'sh7fff, 1'b0);
    send_edge(6'd63, 6'd0, 16'sh8000, 1'b0);
    send_edge(6'd5, 6'd5, 16'sh8000, 1'b0);
    send_edge(6'd63, 6'd1, 16'sh7fff, 1'b1);
    send_edge(6'd7, 6'd7, 16'sh0000, 1'b1);
    for (int i = 0; i < 10; i++)
      send_edge(VTX_W'(i), VTX_W'(i + 1), 16'sh7fff, i == 9);
    for (int i = 0; i < 260; i++)
      send_edge(VTX_W'(i % 64), VTX_W'((i * 7 + 3) % 64), 16'sh8000, i == 259);
    send_edge(6'd3, 6'd4, 16'sd5, 1'b0);
    send_edge(6'd4, 6'd3, 16'sd5, 1'b0);
    send_edge(6'd3, 6'd4, -16'sd5, 1'b1);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 84 : 12) : 0;
      recv_stall = (ph == 2) ? 84 : (ph == 3 ? 12 : 0);
      for (int g = 0; g < 5; g++)
        send_graph($urandom_range(1, 16), $urandom_range(1) ? 8 : 64);
    end
    push <= 0;
    stim_done = 1;
  end

  initial begin
    int guard;
    wait (stim_done);
    guard = 0;
    while (sb.total_q.size() != 0 && guard < 2000000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.total_q.size() == 0) begin
      $display("minimum_spanning_tree_weight regression: pass");
    end else begin
      $display("minimum_spanning_tree_weight regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
